// ===== src/iesg_pkg.sv =====
package iesg_pkg;

  // fixed point format of the radii
  localparam int FRACTION_BITS = 4;

  // field widths
  localparam int RW     = 10;  // radius
  localparam int CXW    = 8;   // center x
  localparam int ROW_W  = 7;   // row offset
  localparam int SOW    = 7;   // second offset
  localparam int HOW    = 7;   // cut ellipse row shift
  localparam int SXW    = 10;  // span x
  localparam int SLW    = 9;   // span length
  localparam int CFG_DW = 10;
  localparam int CFG_IW = 3;

  // half-width result bits: widest is the cut ellipse, 7/5 of the outer x radius
  localparam int HW   = $clog2(((2 ** RW - 1) * 7) / (5 * (2 ** FRACTION_BITS)) + 1);
  localparam int KW   = $clog2(HW);
  localparam int HSQW = 2 * HW;

  // datapath widths
  localparam int DW   = ROW_W + FRACTION_BITS;      // |dy| or |e| scaled
  localparam int DSQW = 2 * DW;
  localparam int SQW  = 2 * RW;                     // radius squared
  localparam int DQW  = (DSQW > SQW) ? DSQW : SQW;  // row vs radius compare
  localparam int LIMW = SQW + 6;                    // 49 * b1^2
  localparam int QW   = DSQW + 5;                   // 25 * e^2
  localparam int LQW  = (LIMW > QW) ? LIMW : QW;
  localparam int SCW  = LIMW;
  localparam int XW   = SQW + SCW;                  // radicand a^2 * s
  localparam int YW   = RW + 3 + FRACTION_BITS;     // divisor b * 5 * 2^F
  localparam int YSQW = 2 * YW;
  localparam int PW   = HSQW + YSQW;                // h^2 * y^2
  localparam int CMW  = (PW > XW) ? PW : XW;
  localparam int CW   = ((HW > CXW) ? HW : CXW) + 3; // span arithmetic

  // job queue
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  typedef enum logic [CFG_IW-1:0] {
    REG_CENTER_X       = 3'd0,
    REG_INNER_RADIUS_X = 3'd1,
    REG_INNER_RADIUS_Y = 3'd2,
    REG_OUTER_RADIUS_X = 3'd3,
    REG_OUTER_RADIUS_Y = 3'd4,
    REG_FILL_INNER     = 3'd5,
    REG_SECOND_OFFSET  = 3'd6,
    REG_CUT_SHIFT      = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [CXW-1:0]        center_x;
    logic [RW-1:0]         inner_radius_x;
    logic [RW-1:0]         inner_radius_y;
    logic [RW-1:0]         outer_radius_x;
    logic [RW-1:0]         outer_radius_y;
    logic                  fill_inner;
    logic [SOW-1:0]        second_offset;
    logic signed [HOW-1:0] cut_shift;
  } cfg_t;

  typedef enum logic [1:0] {
    IM_NONE,
    IM_FULL_IN,
    IM_FULL_OUT,
    IM_SPLIT
  } inner_mode_t;

  typedef struct packed {
    logic [HW-1:0] h1;
    logic [HW-1:0] h0;
    logic [HW-1:0] hc;
    logic          outer_only;
    inner_mode_t   inner_mode;
  } span_job_t;

endpackage

// ===== src/inscribed_ellipse_span_generator.sv =====
// Ellipse ring span generator. Each input item is a row offset from the
// ellipse center; the block answers with zero to ten span items for that
// row (outer rim, optional inner fill split by the cut ellipse, and shifted
// copies when second_offset is nonzero), the row's final span flagged by
// out_last_span. In the front end a row goes through the setup states (load,
// squares, differences, products), then the three bit-serial half-width
// searches in lockstep (a product step and a compare step per result bit,
// seven bits), a state to see them finish and one to push the job; the span
// sequencer then emits one span per cycle while the output is not stalled. A
// two-row job queue between them lets the next row be computed while the
// previous one is still being emitted. Rows outside the outer ellipse
// produce no items. Configuration registers are written through
// cfg_we/cfg_index/cfg_wdata and should only change while the block is idle.
module inscribed_ellipse_span_generator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [iesg_pkg::ROW_W-1:0]   in_row_offset,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [iesg_pkg::SXW-1:0]     out_span_x,
  output logic signed [iesg_pkg::SLW-1:0]     out_span_length,
  output logic                                out_color_select,
  output logic                                out_last_span,
  input  logic                                cfg_we,
  input  logic [iesg_pkg::CFG_IW-1:0]         cfg_index,
  input  logic [iesg_pkg::CFG_DW-1:0]         cfg_wdata
);
  import iesg_pkg::*;

  cfg_t      cfg_r;
  cfg_reg_t  cfg_sel;
  logic      job_push, job_full, job_empty, job_pop;
  span_job_t job_in, job_out;

  assign cfg_sel = cfg_reg_t'(cfg_index);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_x       <= CXW'(95);
      cfg_r.inner_radius_x <= RW'(200);
      cfg_r.inner_radius_y <= RW'(240);
      cfg_r.outer_radius_x <= RW'(280);
      cfg_r.outer_radius_y <= RW'(336);
      cfg_r.fill_inner     <= 1'b1;
      cfg_r.second_offset  <= '0;
      cfg_r.cut_shift      <= '1;
    end else if (cfg_we) begin
      unique case (cfg_sel)
        REG_CENTER_X:       cfg_r.center_x       <= cfg_wdata[CXW-1:0];
        REG_INNER_RADIUS_X: cfg_r.inner_radius_x <= cfg_wdata[RW-1:0];
        REG_INNER_RADIUS_Y: cfg_r.inner_radius_y <= cfg_wdata[RW-1:0];
        REG_OUTER_RADIUS_X: cfg_r.outer_radius_x <= cfg_wdata[RW-1:0];
        REG_OUTER_RADIUS_Y: cfg_r.outer_radius_y <= cfg_wdata[RW-1:0];
        REG_FILL_INNER:     cfg_r.fill_inner     <= cfg_wdata[0];
        REG_SECOND_OFFSET:  cfg_r.second_offset  <= cfg_wdata[SOW-1:0];
        REG_CUT_SHIFT:      cfg_r.cut_shift      <= cfg_wdata[HOW-1:0];
        default: ;
      endcase
    end
  end

  iesg_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_row_offset (in_row_offset),
    .job_valid     (job_push),
    .job_ready     (!job_full),
    .job           (job_in)
  );

  iesg_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .din   (job_in),
    .full  (job_full),
    .pop   (job_pop),
    .empty (job_empty),
    .dout  (job_out)
  );

  iesg_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .job_valid        (!job_empty),
    .job              (job_out),
    .job_pop          (job_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_span_x       (out_span_x),
    .out_span_length  (out_span_length),
    .out_color_select (out_color_select),
    .out_last_span    (out_last_span)
  );

endmodule

// ===== src/iesg_root.sv =====
module iesg_root (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [iesg_pkg::XW-1:0]   x,
  input  logic [iesg_pkg::YSQW-1:0] ysq,
  output logic                      done,
  output logic [iesg_pkg::HW-1:0]   h
);
  import iesg_pkg::*;

  logic            run_r;
  logic            phase_r;
  logic            done_r;
  logic [KW-1:0]   k_r;
  logic [HW-1:0]   h_r;
  logic [HSQW-1:0] tsq_r;
  logic [PW-1:0]   prod_r;

  logic            fit;
  logic [HW-1:0]   h_trial;
  logic [HW-1:0]   h_nxt;
  logic [KW-1:0]   k_dn;
  logic [HW-1:0]   h_trial_dn;
  logic [HSQW-1:0] tsq_nxt;

  // largest h with h^2 * y^2 <= x, one result bit per product and compare step pair
  always_comb begin
    h_trial    = h_r | (HW'(1) << k_r);
    fit        = CMW'(prod_r) <= CMW'(x);
    h_nxt      = fit ? h_trial : h_r;
    k_dn       = k_r - KW'(1);
    h_trial_dn = h_nxt | (HW'(1) << k_dn);
    tsq_nxt    = HSQW'(h_trial_dn) * HSQW'(h_trial_dn);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r   <= 1'b1;
        phase_r <= 1'b0;
        k_r     <= KW'(HW - 1);
        h_r     <= '0;
        tsq_r   <= HSQW'(1) << (2 * (HW - 1));
      end else if (run_r) begin
        if (!phase_r) begin
          // square of the trial value times y^2
          prod_r  <= PW'(tsq_r) * PW'(ysq);
          phase_r <= 1'b1;
        end else begin
          // keep or drop the trial bit
          h_r     <= h_nxt;
          phase_r <= 1'b0;
          if (k_r == '0) begin
            run_r  <= 1'b0;
            done_r <= 1'b1;
          end else begin
            k_r   <= k_dn;
            tsq_r <= tsq_nxt;
          end
        end
      end
    end
  end

  assign done = done_r;
  assign h    = h_r;

endmodule

// ===== src/iesg_front.sv =====
module iesg_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  iesg_pkg::cfg_t                      cfg,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [iesg_pkg::ROW_W-1:0]   in_row_offset,
  output logic                                job_valid,
  input  logic                                job_ready,
  output iesg_pkg::span_job_t                 job
);
  import iesg_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE,
    F_SQ,
    F_DIFF,
    F_MUL,
    F_SEARCH,
    F_PUSH
  } front_state_t;

  front_state_t state_r;

  logic                    buf_valid_r;
  logic signed [ROW_W-1:0] row_r;
  logic signed [ROW_W-1:0] dy_r;

  logic [DSQW-1:0] dsq_r, esq_r;
  logic [SQW-1:0]  b1sq_r, b0sq_r, a1sq_r, a0sq_r;
  logic            outside_r, inner_r, cut_in_r;
  logic [SQW-1:0]  s1_r, s0_r;
  logic [SCW-1:0]  sc_r;
  logic [YW-1:0]   y1_r, y0_r, yc_r;
  logic [XW-1:0]   x1_r, x0_r, xc_r;
  logic [YSQW-1:0] y1sq_r, y0sq_r, ycsq_r;

  logic [ROW_W-1:0]  dabs;
  logic signed [ROW_W:0] e_s;
  logic [ROW_W:0]    e_abs;
  logic [DW-1:0]     d_sc, e_sc;
  logic [LIMW-1:0]   lim;
  logic [QW-1:0]     q;
  logic              start;
  logic              done1, done0, donec;
  logic [HW-1:0]     h1, h0, hc;

  // row distance to the centers of the ring and of the cut ellipse
  always_comb begin
    dabs  = dy_r[ROW_W-1] ? ROW_W'(-dy_r) : ROW_W'(dy_r);
    e_s   = {dy_r[ROW_W-1], dy_r} - {cfg.cut_shift[HOW-1], cfg.cut_shift};
    e_abs = e_s[ROW_W] ? (ROW_W+1)'(-e_s) : (ROW_W+1)'(e_s);
    d_sc  = DW'(dabs) << FRACTION_BITS;
    e_sc  = DW'(e_abs[ROW_W-1:0]) << FRACTION_BITS;
  end

  // 49 * b1^2 and 25 * e^2 as shift-add
  always_comb begin
    lim = (LIMW'(b1sq_r) << 5) + (LIMW'(b1sq_r) << 4) + LIMW'(b1sq_r);
    q   = (QW'(esq_r) << 4) + (QW'(esq_r) << 3) + QW'(esq_r);
  end

  assign in_ready = !buf_valid_r;
  assign start    = (state_r == F_MUL) && !outside_r;

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= F_IDLE;
      buf_valid_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        buf_valid_r <= 1'b1;
        row_r       <= in_row_offset;
      end
      unique case (state_r)
        F_IDLE: begin
          if (buf_valid_r) begin
            dy_r        <= row_r;
            buf_valid_r <= 1'b0;
            state_r     <= F_SQ;
          end
        end
        F_SQ: begin
          dsq_r   <= DSQW'(d_sc) * DSQW'(d_sc);
          esq_r   <= DSQW'(e_sc) * DSQW'(e_sc);
          b1sq_r  <= SQW'(cfg.outer_radius_y) * SQW'(cfg.outer_radius_y);
          b0sq_r  <= SQW'(cfg.inner_radius_y) * SQW'(cfg.inner_radius_y);
          a1sq_r  <= SQW'(cfg.outer_radius_x) * SQW'(cfg.outer_radius_x);
          a0sq_r  <= SQW'(cfg.inner_radius_x) * SQW'(cfg.inner_radius_x);
          state_r <= F_DIFF;
        end
        F_DIFF: begin
          outside_r <= (cfg.outer_radius_y == '0) || (DQW'(dsq_r) > DQW'(b1sq_r));
          inner_r   <= (cfg.inner_radius_y != '0) && (DQW'(dsq_r) < DQW'(b0sq_r));
          cut_in_r  <= !cfg.cut_shift[HOW-1] && (LQW'(q) < LQW'(lim));
          s1_r      <= b1sq_r - SQW'(dsq_r);
          s0_r      <= b0sq_r - SQW'(dsq_r);
          sc_r      <= SCW'(lim) - SCW'(q);
          y1_r      <= YW'(cfg.outer_radius_y) << FRACTION_BITS;
          y0_r      <= YW'(cfg.inner_radius_y) << FRACTION_BITS;
          yc_r      <= ((YW'(cfg.outer_radius_y) << 2) + YW'(cfg.outer_radius_y))
                       << FRACTION_BITS;
          state_r   <= F_MUL;
        end
        F_MUL: begin
          x1_r   <= XW'(a1sq_r) * XW'(s1_r);
          x0_r   <= XW'(a0sq_r) * XW'(s0_r);
          xc_r   <= XW'(a1sq_r) * XW'(sc_r);
          y1sq_r <= YSQW'(y1_r) * YSQW'(y1_r);
          y0sq_r <= YSQW'(y0_r) * YSQW'(y0_r);
          ycsq_r <= YSQW'(yc_r) * YSQW'(yc_r);
          state_r <= outside_r ? F_IDLE : F_SEARCH;
        end
        F_SEARCH: begin
          if (done1 && done0 && donec) begin
            state_r <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (job_ready) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  // three half-width searches run in lockstep
  iesg_root u_root_outer (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .x     (x1_r),
    .ysq   (y1sq_r),
    .done  (done1),
    .h     (h1)
  );

  iesg_root u_root_inner (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .x     (x0_r),
    .ysq   (y0sq_r),
    .done  (done0),
    .h     (h0)
  );

  iesg_root u_root_cut (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .x     (xc_r),
    .ysq   (ycsq_r),
    .done  (donec),
    .h     (hc)
  );

  // classify the row for the span sequencer
  always_comb begin
    job.h1         = h1;
    job.h0         = h0;
    job.hc         = hc;
    job.outer_only = !inner_r;
    if (!cfg.fill_inner) begin
      job.inner_mode = IM_NONE;
    end else if (!cut_in_r) begin
      job.inner_mode = IM_FULL_IN;
    end else if (hc <= h0) begin
      job.inner_mode = IM_SPLIT;
    end else begin
      job.inner_mode = IM_FULL_OUT;
    end
  end

  assign job_valid = (state_r == F_PUSH);

endmodule

// ===== src/iesg_fifo.sv =====
module iesg_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  iesg_pkg::span_job_t din,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output iesg_pkg::span_job_t dout
);
  import iesg_pkg::*;

  span_job_t      mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] rd_ptr_r;
  logic [QAW:0]   count_r;

  assign full  = (count_r == (QAW+1)'(QDEPTH));
  assign empty = (count_r == '0);
  assign dout  = mem_r[rd_ptr_r];

  // job storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= (wr_ptr_r == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_r + QAW'(1);
      end
      if (pop && !empty) begin
        rd_ptr_r <= (rd_ptr_r == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_r + QAW'(1);
      end
      count_r <= count_r + (QAW+1)'(push && !full) - (QAW+1)'(pop && !empty);
    end
  end

endmodule

// ===== src/iesg_back.sv =====
module iesg_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  iesg_pkg::cfg_t                     cfg,
  input  logic                               job_valid,
  input  iesg_pkg::span_job_t                job,
  output logic                               job_pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [iesg_pkg::SXW-1:0]    out_span_x,
  output logic signed [iesg_pkg::SLW-1:0]    out_span_length,
  output logic                               out_color_select,
  output logic                               out_last_span
);
  import iesg_pkg::*;

  logic       grp_r;   // 0 rim or outer span, 1 inner area
  logic       dup_r;   // 1 while emitting the shifted copies
  logic [1:0] idx_r;

  logic                    out_valid_r;
  logic signed [SXW-1:0]   span_x_r;
  logic signed [SLW-1:0]   span_len_r;
  logic                    color_r;
  logic                    last_r;

  logic                 advance;
  logic                 dup_en;
  logic [1:0]           n1, n2, n_cur;
  logic                 idx_last, grp_end, row_end;
  logic signed [CW-1:0] cx, h1, h0, hc, so;
  logic signed [CW-1:0] bx, bl, sx;
  logic                 col;

  always_comb begin
    cx = CW'(cfg.center_x);
    so = CW'(cfg.second_offset);
    h1 = CW'(job.h1);
    h0 = CW'(job.h0);
    hc = CW'(job.hc);
  end

  // span counts per group
  always_comb begin
    dup_en = (cfg.second_offset != '0);
    n1     = job.outer_only ? 2'd1 : 2'd2;
    case (job.inner_mode)
      IM_NONE:  n2 = 2'd0;
      IM_SPLIT: n2 = 2'd3;
      default:  n2 = 2'd1;
    endcase
    if (job.outer_only) begin
      n2 = 2'd0;
    end
    n_cur    = grp_r ? n2 : n1;
    idx_last = (idx_r == n_cur - 2'd1);
    grp_end  = idx_last && (!dup_en || dup_r);
    row_end  = grp_end && (grp_r || (n2 == 2'd0));
  end

  // span geometry for the current step
  always_comb begin
    bx  = cx - h1;
    bl  = (h1 <<< 1) + CW'(1);
    col = 1'b1;
    if (!grp_r) begin
      if (!job.outer_only) begin
        bl = h1 - h0 + CW'(1);
        bx = (idx_r == 2'd1) ? cx + h0 : cx - h1;
      end
    end else if (job.inner_mode == IM_SPLIT) begin
      case (idx_r)
        2'd0: begin
          bx  = cx - h0;
          bl  = h0 - hc + CW'(1);
          col = 1'b0;
        end
        2'd1: begin
          bx  = cx - hc;
          bl  = (hc <<< 1) + CW'(1);
          col = 1'b1;
        end
        default: begin
          bx  = cx + hc;
          bl  = h0 - hc + CW'(1);
          col = 1'b0;
        end
      endcase
    end else begin
      bx  = cx - h0;
      bl  = (h0 <<< 1) + CW'(1);
      col = (job.inner_mode == IM_FULL_OUT);
    end
    sx = bx + (dup_r ? so : CW'(0));
  end

  assign advance = job_valid && (!out_valid_r || out_ready);
  assign job_pop = advance && row_end;

  // step counters and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      grp_r       <= 1'b0;
      dup_r       <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (advance) begin
        out_valid_r <= 1'b1;
        span_x_r    <= sx[SXW-1:0];
        span_len_r  <= bl[SLW-1:0];
        color_r     <= col;
        last_r      <= row_end;
        if (grp_end) begin
          grp_r <= !row_end;
          dup_r <= 1'b0;
          idx_r <= '0;
        end else if (idx_last) begin
          dup_r <= 1'b1;
          idx_r <= '0;
        end else begin
          idx_r <= idx_r + 2'd1;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_span_x       = span_x_r;
  assign out_span_length  = span_len_r;
  assign out_color_select = color_r;
  assign out_last_span    = last_r;

endmodule
